[rtl/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and codes for the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned ReqW  = 3;

  typedef enum logic [ReqW-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_GCD_START,
    ST_GCD_STEP,
    ST_GCD_SWAP,
    ST_QN_START,
    ST_QN_STEP,
    ST_QD_START,
    ST_QD_STEP,
    ST_FINISH,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic sum;
    logic div_start_gcd;
    logic div_start_qn;
    logic div_start_qd;
    logic div_step;
    logic gcd_swap;
    logic store_qn;
    logic store_qd;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic early;      // result known without reduction
    logic div_done;
    logic rem_zero;   // gcd loop remainder is zero
  } sts_t;

endpackage

[rtl/rau_ctrl.sv]
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer for products, gcd and exact division steps
// ----------------------------------------------------------------------------
module rau_ctrl
  import rau_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_valid_i,
  output logic s_ready_o,
  output logic m_valid_o,
  input  logic m_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (s_valid_i) state_d = ST_MUL1;
      ST_MUL1:      state_d = ST_MUL2;
      ST_MUL2:      state_d = ST_SUM;
      ST_SUM:       state_d = sts_i.early ? ST_OUT : ST_GCD_START;
      ST_GCD_START: state_d = ST_GCD_STEP;
      ST_GCD_STEP:  if (sts_i.div_done) state_d = ST_GCD_SWAP;
      ST_GCD_SWAP:  state_d = sts_i.rem_zero ? ST_QN_START : ST_GCD_START;
      ST_QN_START:  state_d = ST_QN_STEP;
      ST_QN_STEP:   if (sts_i.div_done) state_d = ST_QD_START;
      ST_QD_START:  state_d = ST_QD_STEP;
      ST_QD_STEP:   if (sts_i.div_done) state_d = ST_FINISH;
      ST_FINISH:    state_d = ST_OUT;
      ST_OUT:       if (m_ready_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    s_ready_o = 1'b0;
    m_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        cmd_o.load = s_valid_i;
      end
      ST_MUL1:      cmd_o.mul1 = 1'b1;
      ST_MUL2:      cmd_o.mul2 = 1'b1;
      ST_SUM:       cmd_o.sum = 1'b1;
      ST_GCD_START: cmd_o.div_start_gcd = 1'b1;
      ST_GCD_STEP:  cmd_o.div_step = 1'b1;
      ST_GCD_SWAP:  cmd_o.gcd_swap = 1'b1;
      ST_QN_START:  cmd_o.div_start_qn = 1'b1;
      ST_QN_STEP: begin
        cmd_o.div_step = 1'b1;
        cmd_o.store_qn = sts_i.div_done;
      end
      ST_QD_START:  cmd_o.div_start_qd = 1'b1;
      ST_QD_STEP: begin
        cmd_o.div_step = 1'b1;
        cmd_o.store_qd = sts_i.div_done;
      end
      ST_FINISH:    cmd_o.finish = 1'b1;
      ST_OUT:       m_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

[rtl/rau_dpath.sv]
// ----------------------------------------------------------------------------
// rau_dpath
// operand registers, shared 32x32 multiplier, restoring divider
// ----------------------------------------------------------------------------
module rau_dpath
  import rau_pkg::*;
#(
  parameter int unsigned NUM_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [ReqW-1:0]      req_type_i,
  input  logic [NUM_WIDTH-1:0] a_num_i,
  input  logic [NUM_WIDTH-1:0] a_den_i,
  input  logic [NUM_WIDTH-1:0] b_num_i,
  input  logic [NUM_WIDTH-1:0] b_den_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic [NUM_WIDTH-1:0] res_num_o,
  output logic [NUM_WIDTH-1:0] res_den_o,
  output logic                 is_less_o,
  output logic                 is_equal_o,
  output logic                 is_greater_o,
  output logic                 overflow_o,
  output logic                 div_zero_o
);

  localparam int unsigned W2   = 2 * NUM_WIDTH;
  localparam int unsigned CntW = $clog2(W2 + 1);

  logic [ReqW-1:0]      op_q;
  logic [NUM_WIDTH-1:0] am_q, ad_q, bm_q, bd_q;
  logic                 an_q, bn_q;
  logic [W2-1:0]        p1_q, p2_q, den_q;
  logic                 p1n_q, p2n_q;
  logic [W2-1:0]        num_q;
  logic                 neg_q;
  logic [W2-1:0]        gx_q, gy_q;
  logic [W2-1:0]        dvd_q, dvs_q, quo_q;
  logic [W2:0]          rem_q;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q;
  logic [W2-1:0]        qn_q;
  logic [NUM_WIDTH-1:0] rn_q, rd_q;
  logic                 lt_q, eq_q, gt_q, ov_q, dz_q, early_q;

  logic [NUM_WIDTH-1:0] am_d, bm_d;
  logic [NUM_WIDTH-1:0] mul_x, mul_y;
  logic [W2-1:0]        mul_p;
  logic                 s2neg;
  logic [W2-1:0]        sum_mag;
  logic                 sum_neg;
  logic                 sum_early;
  logic [W2:0]          rem_sh, rem_sub;
  logic [W2-1:0]        quo_nx;
  logic [W2-1:0]        lim;
  logic                 zd, dz_in, bad_op;

  assign am_d = a_num_i[NUM_WIDTH-1] ? (~a_num_i + 1'b1) : a_num_i;
  assign bm_d = b_num_i[NUM_WIDTH-1] ? (~b_num_i + 1'b1) : b_num_i;

  // operand selection for the shared multiplier
  always_comb begin
    mul_x = ad_q;
    mul_y = bd_q;
    if (cmd_i.mul1) begin
      unique case (op_q)
        OP_MUL:  begin mul_x = am_q; mul_y = bm_q; end
        OP_DIV:  begin mul_x = am_q; mul_y = bd_q; end
        default: begin mul_x = am_q; mul_y = bd_q; end
      endcase
    end else begin
      unique case (op_q)
        OP_MUL:  begin mul_x = ad_q; mul_y = bd_q; end
        OP_DIV:  begin mul_x = ad_q; mul_y = bm_q; end
        default: begin mul_x = bm_q; mul_y = ad_q; end
      endcase
    end
  end
  assign mul_p = W2'(mul_x) * W2'(mul_y);

  // signed sum of the two cross products
  always_comb begin
    s2neg = p2n_q;
    if (op_q != OP_ADD) s2neg = ~p2n_q;
    if (p1n_q == s2neg) begin
      sum_mag = p1_q + p2_q;
      sum_neg = p1n_q;
    end else if (p1_q >= p2_q) begin
      sum_mag = p1_q - p2_q;
      sum_neg = p1n_q;
    end else begin
      sum_mag = p2_q - p1_q;
      sum_neg = s2neg;
    end
    if (sum_mag == '0) sum_neg = 1'b0;
  end

  // compare and zero results need no reduction
  assign sum_early = (op_q == OP_CMP) ||
                     (((op_q == OP_MUL) || (op_q == OP_DIV)) ? (p1_q == '0)
                                                             : (sum_mag == '0));

  assign rem_sh  = {rem_q[W2-1:0], dvd_q[W2-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign quo_nx  = {quo_q[W2-2:0], ~rem_sub[W2]};
  assign lim     = neg_q ? (W2'(1) << (NUM_WIDTH - 1))
                         : ((W2'(1) << (NUM_WIDTH - 1)) - W2'(1));
  assign zd      = (a_den_i == '0) || (b_den_i == '0);
  assign dz_in   = zd || ((req_type_i == OP_DIV) && (b_num_i == '0));
  assign bad_op  = req_type_i > OP_CMP;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.div_start_gcd || cmd_i.div_start_qn || cmd_i.div_start_qd) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(W2);
    end else if (cmd_i.div_step && busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= req_type_i;
      am_q <= am_d;
      bm_q <= bm_d;
      an_q <= a_num_i[NUM_WIDTH-1];
      bn_q <= b_num_i[NUM_WIDTH-1];
      ad_q <= a_den_i;
      bd_q <= b_den_i;
      lt_q <= 1'b0;
      eq_q <= 1'b0;
      gt_q <= 1'b0;
      ov_q <= 1'b0;
      rn_q <= '0;
      rd_q <= '0;
      dz_q <= dz_in && !bad_op;
      early_q <= bad_op || dz_in;
    end
    if (cmd_i.mul1) begin
      p1_q  <= mul_p;
      p1n_q <= (op_q == OP_MUL || op_q == OP_DIV) ? (an_q ^ bn_q) : an_q;
    end
    if (cmd_i.mul2) begin
      if (op_q == OP_MUL || op_q == OP_DIV) begin
        den_q <= mul_p;
      end else begin
        p2_q  <= mul_p;
        p2n_q <= bn_q && (mul_p != '0);
        den_q <= W2'(ad_q) * W2'(bd_q);
      end
    end
    if (cmd_i.sum && !early_q) begin
      if (op_q == OP_MUL || op_q == OP_DIV) begin
        num_q <= p1_q;
        neg_q <= p1n_q && (p1_q != '0);
        gx_q  <= p1_q;
        if (p1_q == '0) begin
          early_q <= 1'b1;
          rd_q    <= NUM_WIDTH'(1);
        end
      end else begin
        num_q <= sum_mag;
        neg_q <= sum_neg;
        gx_q  <= sum_mag;
        if (op_q == OP_CMP) begin
          early_q <= 1'b1;
          lt_q <= sum_neg;
          eq_q <= sum_mag == '0;
          gt_q <= !sum_neg && (sum_mag != '0);
        end else if (sum_mag == '0) begin
          early_q <= 1'b1;
          rd_q    <= NUM_WIDTH'(1);
        end
      end
      gy_q <= den_q;
    end
    // restoring divider: dvd / dvs
    if (cmd_i.div_start_gcd) begin
      dvd_q <= gx_q;
      dvs_q <= gy_q;
      rem_q <= '0;
    end
    if (cmd_i.div_start_qn) begin
      dvd_q <= num_q;
      dvs_q <= gx_q;
      rem_q <= '0;
    end
    if (cmd_i.div_start_qd) begin
      dvd_q <= den_q;
      dvs_q <= gx_q;
      rem_q <= '0;
    end
    if (cmd_i.div_step && busy_q) begin
      dvd_q <= {dvd_q[W2-2:0], 1'b0};
      if (!rem_sub[W2]) begin
        rem_q <= rem_sub;
        quo_q <= {quo_q[W2-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[W2-2:0], 1'b0};
      end
    end
    // euclid step: (x, y) <- (y, x mod y)
    if (cmd_i.gcd_swap) begin
      if (rem_q[W2-1:0] != '0) begin
        gx_q <= gy_q;
        gy_q <= rem_q[W2-1:0];
      end else begin
        gx_q <= gy_q;
      end
    end
    // quotient taken with its last bit on the final step
    if (cmd_i.store_qn) qn_q <= quo_nx;
    if (cmd_i.store_qd) den_q <= quo_nx;
    if (cmd_i.finish) begin
      if (qn_q > lim || den_q[W2-1:NUM_WIDTH] != '0) begin
        ov_q <= 1'b1;
      end else begin
        rn_q <= neg_q ? (~qn_q[NUM_WIDTH-1:0] + 1'b1) : qn_q[NUM_WIDTH-1:0];
        rd_q <= den_q[NUM_WIDTH-1:0];
      end
    end
  end

  assign sts_o.early    = early_q || (cmd_i.sum && sum_early);
  assign sts_o.div_done = busy_q && (cnt_q == CntW'(1));
  assign sts_o.rem_zero = rem_q[W2-1:0] == '0;

  assign res_num_o    = rn_q;
  assign res_den_o    = rd_q;
  assign is_less_o    = lt_q;
  assign is_equal_o   = eq_q;
  assign is_greater_o = gt_q;
  assign overflow_o   = ov_q;
  assign div_zero_o   = dz_q;

endmodule

[rtl/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// exact fraction add, subtract, multiply, divide and compare with gcd reduction
// ----------------------------------------------------------------------------
// channel   dir  tdata fields (low bit up)                           tuser
// s_axis    in   a_num, a_den, b_num, b_den                           req_type
// m_axis    out  res_num, res_den, is_less, is_equal, is_greater,
//                overflow, div_zero                                    -
//
// one item at a time; flagged, trivial and compare items skip reduction, others
// run euclid steps, then numerator and denominator quotients, on the bit-serial
// restoring divider shared by gcd and final quotients; reset is asynchronous
// active low, idles the sequencer and clears the divider busy flag and count
// the result waits in its register until taken; input is held off till then
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int unsigned NUM_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
  input  logic [127:0] s_axis_tdata,
  // req_type[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // res_num[31:0], res_den[63:32], is_less[64], is_equal[65],
  // is_greater[66], overflow[67], div_zero[68], zero fill up to 71
  output logic [71:0]  m_axis_tdata
);

  cmd_t cmd;
  sts_t sts;
  logic [NUM_WIDTH-1:0] rn, rd;
  logic lt, eq, gt, ov, dz;

  rau_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // only the low NUM_WIDTH bits of each operand take part
  rau_dpath #(.NUM_WIDTH(NUM_WIDTH)) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_type_i   (s_axis_tuser),
    .a_num_i      (s_axis_tdata[NUM_WIDTH-1:0]),
    .a_den_i      (s_axis_tdata[32 +: NUM_WIDTH]),
    .b_num_i      (s_axis_tdata[64 +: NUM_WIDTH]),
    .b_den_i      (s_axis_tdata[96 +: NUM_WIDTH]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .res_num_o    (rn),
    .res_den_o    (rd),
    .is_less_o    (lt),
    .is_equal_o   (eq),
    .is_greater_o (gt),
    .overflow_o   (ov),
    .div_zero_o   (dz)
  );

  // numerator sign-extended, denominator zero-extended to the 32-bit fields
  assign m_axis_tdata = {3'b000, dz, ov, gt, eq, lt,
                         32'(rd), 32'(signed'(rn))};

endmodule
